FILE: rtl/gmg_pkg.sv
// Shared types, codes and helpers of the grid maze generator.
package gmg_pkg;

  // Command opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_START = 2'd3;

  // Directions as carried in passage_dir and the open side bits
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Neighbor scan order: right, left, down, up
  localparam logic [1:0] SCAN_ORDER [4] = '{DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP};

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [30:0] pick_random;
    logic [30:0] passage_random;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  out_x;
    logic [4:0]  out_y;
    logic [1:0]  passage_dir;
    logic [3:0]  open_sides;
    logic [10:0] frontier_size;
  } out_word_t;

  // One word of the cell store
  typedef struct packed {
    logic       queued;
    logic       visited;
    logic [3:0] walls;
  } cell_word_t;

  // Frontier chain command, broadcast to every cell
  typedef struct packed {
    logic remove;
    logic append;
  } chain_op_t;

  function automatic logic [3:0] dir_bit(input logic [1:0] d);
    return 4'b0001 << d;
  endfunction

  function automatic logic [1:0] opposite_dir(input logic [1:0] d);
    return d + 2'd2;
  endfunction

endpackage

FILE: rtl/gmg_cell.sv
// One frontier cell: holds one queued entry, shifts from its upper neighbor on removal.
module gmg_cell #(
  parameter int EW  = 10,
  parameter int PW  = 11,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  gmg_pkg::chain_op_t  op,
  input  logic [PW-1:0]       pick,
  input  logic [PW-1:0]       tail,
  input  logic [EW-1:0]       fill,
  input  logic [EW-1:0]       upper,
  output logic [EW-1:0]       entry
);

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  // Close the gap at or above the removed place, or take the appended word at the tail
  always_ff @(posedge clk) begin
    if (op.remove && (MY_POS >= pick)) begin
      entry <= upper;
    end else if (op.append && (MY_POS == tail)) begin
      entry <= fill;
    end
  end

endmodule

FILE: rtl/gmg_chain.sv
// Frontier list as a row of cells, with a registered two-level readout of one entry.
module gmg_chain #(
  parameter int N  = 1024,
  parameter int EW = 10,
  parameter int PW = 11
) (
  input  logic                clk,
  input  gmg_pkg::chain_op_t  op,
  input  logic [PW-1:0]       pick,
  input  logic [PW-1:0]       tail,
  input  logic [EW-1:0]       fill,
  output logic [EW-1:0]       sel_entry
);

  localparam int GROUP = 32;
  localparam int NG    = (N + GROUP - 1) / GROUP;

  logic [EW-1:0] entries  [N];
  logic [EW-1:0] grp_comb [NG];
  logic [EW-1:0] grp_q    [NG];
  logic [EW-1:0] top_comb;

  // Build the row; the last cell takes zero from above
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [EW-1:0] upper;
    if (i == N - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid
      assign upper = entries[i+1];
    end
    gmg_cell #(.EW(EW), .PW(PW), .IDX(i)) u_cell (
      .clk   (clk),
      .op    (op),
      .pick  (pick),
      .tail  (tail),
      .fill  (fill),
      .upper (upper),
      .entry (entries[i])
    );
  end

  // First level: select within each group of cells
  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      grp_comb[g] = '0;
      for (int i = 0; i < GROUP; i++) begin
        if ((g * GROUP + i) < N) begin
          if (PW'(g * GROUP + i) == pick) begin
            grp_comb[g] = grp_comb[g] | entries[g * GROUP + i];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      grp_q[g] <= grp_comb[g];
    end
  end

  // Second level: merge the group results
  always_comb begin
    top_comb = '0;
    for (int g = 0; g < NG; g++) begin
      top_comb = top_comb | grp_q[g];
    end
  end

  always_ff @(posedge clk) begin
    sel_entry <= top_comb;
  end

endmodule

FILE: rtl/gmg_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
module gmg_mod #(
  parameter int DW = 31,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_sh;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] left;
  logic [VW:0]     trial;

  // Shift the next dividend bit into the partial remainder
  always_comb begin
    trial = {rem, quo_sh[DW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        quo_sh <= dividend;
        dvs    <= divisor;
        rem    <= '0;
        left   <= CNTW'(DW);
      end else if (left != '0) begin
        quo_sh <= quo_sh << 1;
        if (trial >= {1'b0, dvs}) begin
          rem <= VW'(trial - {1'b0, dvs});
        end else begin
          rem <= VW'(trial);
        end
        left <= left - CNTW'(1);
        if (left == CNTW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/grid_maze_generator.sv
// Randomized Prim maze generator: sequencer, cell store, frontier chain and remainder unit.
// Start: a clearing pass over all MAX_COLUMNS*MAX_ROWS cells of the cell store, then the seed scan.
// Step: a remainder pass to pick an entry, and a second one only when a visited neighbor exists.
// Read: states S_RDRQ then S_RDWT. Empty-frontier step: result in the cycle after the word is taken.
// One word at a time; busy stays high until the result strobe.
// Reset (synchronous, rst high) runs the clearing pass with busy high; sizes reset to 32, or the maximum if smaller.
module grid_maze_generator #(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_ROWS    = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  gmg_pkg::in_word_t  cmd,
  output logic               done,
  output gmg_pkg::out_word_t result,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [5:0]         wr_data
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = $clog2(CELL_COUNT);
  localparam int PW = $clog2(CELL_COUNT + 1);
  localparam int EW = CW + RW;

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_SEED  = 16'h0004,
    S_DIV1  = 16'h0008,
    S_PICK  = 16'h0010,
    S_OWNRQ = 16'h0020,
    S_OWNWT = 16'h0040,
    S_NBRRQ = 16'h0080,
    S_NBRWT = 16'h0100,
    S_AFTER = 16'h0200,
    S_DIV2  = 16'h0400,
    S_OPRQ  = 16'h0800,
    S_OPWT  = 16'h1000,
    S_OPOWN = 16'h2000,
    S_RDRQ  = 16'h4000,
    S_RDWT  = 16'h8000
  } state_t;

  function automatic logic [5:0] clamp_dim(input logic [5:0] v, input int limit);
    if (v == 6'd0) begin
      return 6'd1;
    end else if (int'(v) > limit) begin
      return 6'(limit);
    end else begin
      return v;
    end
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [RW-1:0] y);
    return AW'(int'(y) * MAX_COLUMNS + int'(x));
  endfunction

  state_t              state;
  gmg_pkg::in_word_t   cmd_q;
  logic [5:0]          grid_w;
  logic [5:0]          grid_h;
  logic [AW-1:0]       clr_addr;
  logic                seed_pending;
  logic [PW-1:0]       count;
  logic [PW-1:0]       pick;
  logic [1:0]          pick_wait;
  logic [2:0]          step;
  logic [CW-1:0]       ent_x;
  logic [RW-1:0]       ent_y;
  gmg_pkg::cell_word_t own_word;
  logic [CW-1:0]       nq_x;
  logic [RW-1:0]       nq_y;
  logic [1:0]          nq_dir;
  logic [1:0]          cand_dir [4];
  logic [CW-1:0]       cand_x   [4];
  logic [RW-1:0]       cand_y   [4];
  logic [2:0]          nc;
  logic [1:0]          pdir;
  logic [CW-1:0]       tgt_x;
  logic [RW-1:0]       tgt_y;

  // Cell store
  gmg_pkg::cell_word_t maze_mem [CELL_COUNT];
  gmg_pkg::cell_word_t mem_rd;
  gmg_pkg::cell_word_t mem_wd;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [AW-1:0]       mem_ra;

  // Neighbor and seed helpers
  logic [CW-1:0]       base_x;
  logic [RW-1:0]       base_y;
  logic [1:0]          scan_dir;
  logic [CW-1:0]       nbr_x;
  logic [RW-1:0]       nbr_y;
  logic                nbr_ok;
  logic [CW-1:0]       seed_x;
  logic [RW-1:0]       seed_y;
  logic                rd_ok;
  logic [AW-1:0]       own_addr;
  gmg_pkg::cell_word_t fresh_word;

  // Frontier chain and remainder unit
  gmg_pkg::chain_op_t  chain_op;
  logic [EW-1:0]       chain_fill;
  logic [EW-1:0]       sel_entry;
  logic                div_go;
  logic [30:0]         div_a;
  logic [PW-1:0]       div_d;
  logic                div_done;
  logic [PW-1:0]       div_rem;

  assign busy     = (state != S_IDLE);
  assign own_addr = cell_addr(ent_x, ent_y);

  // Clamp the seed into the grid in use; check a read address against it
  always_comb begin
    seed_x = CW'(({1'b0, cmd_q.cell_x} >= grid_w) ? (grid_w - 6'd1) : {1'b0, cmd_q.cell_x});
    seed_y = RW'(({1'b0, cmd_q.cell_y} >= grid_h) ? (grid_h - 6'd1) : {1'b0, cmd_q.cell_y});
    rd_ok  = ({1'b0, cmd_q.cell_x} < grid_w) && ({1'b0, cmd_q.cell_y} < grid_h) &&
             (int'(cmd_q.cell_x) < MAX_COLUMNS) && (int'(cmd_q.cell_y) < MAX_ROWS);
  end

  // Neighbor of the seed or the added cell in the current scan direction
  always_comb begin
    base_x   = (state == S_SEED) ? seed_x : ent_x;
    base_y   = (state == S_SEED) ? seed_y : ent_y;
    scan_dir = gmg_pkg::SCAN_ORDER[step[1:0]];
    nbr_x    = base_x;
    nbr_y    = base_y;
    nbr_ok   = 1'b0;
    case (scan_dir)
      gmg_pkg::DIR_RIGHT: begin
        nbr_ok = (int'(base_x) + 1 < int'(grid_w)) && (int'(base_x) + 1 < MAX_COLUMNS);
        nbr_x  = CW'(int'(base_x) + 1);
      end
      gmg_pkg::DIR_UP: begin
        nbr_ok = (base_y != '0);
        nbr_y  = base_y - RW'(1);
      end
      gmg_pkg::DIR_LEFT: begin
        nbr_ok = (base_x != '0);
        nbr_x  = base_x - CW'(1);
      end
      default: begin
        nbr_ok = (int'(base_y) + 1 < int'(grid_h)) && (int'(base_y) + 1 < MAX_ROWS);
        nbr_y  = RW'(int'(base_y) + 1);
      end
    endcase
  end

  // The added cell, marked visited and dropped from the frontier
  always_comb begin
    fresh_word         = mem_rd;
    fresh_word.visited = 1'b1;
    fresh_word.queued  = 1'b0;
  end

  // Drive the store ports, the chain and the remainder unit per state
  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = own_addr;
    mem_wd     = mem_rd;
    mem_ra     = own_addr;
    chain_op   = '0;
    chain_fill = {nbr_y, nbr_x};
    div_go     = 1'b0;
    div_a      = cmd.pick_random;
    div_d      = count;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '0;
      end
      S_IDLE: begin
        div_go = start && (cmd.opcode == gmg_pkg::OP_STEP) && (count != '0);
      end
      S_SEED: begin
        if (step[2]) begin
          mem_we = 1'b1;
          mem_wa = cell_addr(seed_x, seed_y);
          mem_wd = '{queued: 1'b0, visited: 1'b1, walls: 4'd0};
        end else if (nbr_ok) begin
          mem_we          = 1'b1;
          mem_wa          = cell_addr(nbr_x, nbr_y);
          mem_wd          = '{queued: 1'b1, visited: 1'b0, walls: 4'd0};
          chain_op.append = 1'b1;
        end
      end
      S_PICK: begin
        chain_op.remove = (pick_wait == 2'd2);
      end
      S_OWNWT: begin
        mem_we = 1'b1;
        mem_wd = fresh_word;
      end
      S_NBRRQ: begin
        mem_ra = cell_addr(nbr_x, nbr_y);
      end
      S_NBRWT: begin
        chain_fill = {nq_y, nq_x};
        mem_wa     = cell_addr(nq_x, nq_y);
        if (!mem_rd.visited && !mem_rd.queued) begin
          mem_we          = 1'b1;
          mem_wd.queued   = 1'b1;
          chain_op.append = 1'b1;
        end
      end
      S_AFTER: begin
        div_go = (nc != 3'd0);
        div_a  = cmd_q.passage_random;
        div_d  = PW'(nc);
      end
      S_OPRQ: begin
        mem_ra = cell_addr(tgt_x, tgt_y);
      end
      S_OPWT: begin
        mem_we       = 1'b1;
        mem_wa       = cell_addr(tgt_x, tgt_y);
        mem_wd.walls = mem_rd.walls | gmg_pkg::dir_bit(gmg_pkg::opposite_dir(pdir));
      end
      S_OPOWN: begin
        mem_we       = 1'b1;
        mem_wd       = own_word;
        mem_wd.walls = own_word.walls | gmg_pkg::dir_bit(pdir);
      end
      S_RDRQ: begin
        mem_ra = cell_addr(CW'(cmd_q.cell_x), RW'(cmd_q.cell_y));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      maze_mem[mem_wa] <= mem_wd;
    end
    mem_rd <= maze_mem[mem_ra];
  end

  gmg_chain #(.N(CELL_COUNT), .EW(EW), .PW(PW)) u_chain (
    .clk       (clk),
    .op        (chain_op),
    .pick      (pick),
    .tail      (count),
    .fill      (chain_fill),
    .sel_entry (sel_entry)
  );

  gmg_mod #(.DW(31), .VW(PW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      seed_pending <= 1'b0;
      count        <= '0;
      done         <= 1'b0;
      grid_w       <= clamp_dim(6'd32, MAX_COLUMNS);
      grid_h       <= clamp_dim(6'd32, MAX_ROWS);
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          gmg_pkg::REG_GRID_WIDTH:  grid_w <= clamp_dim(wr_data, MAX_COLUMNS);
          gmg_pkg::REG_GRID_HEIGHT: grid_h <= clamp_dim(wr_data, MAX_ROWS);
          default: begin
          end
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELL_COUNT - 1)) begin
            clr_addr <= '0;
            step     <= '0;
            state    <= seed_pending ? S_SEED : S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            unique case (cmd.opcode)
              gmg_pkg::OP_START: begin
                seed_pending <= 1'b1;
                count        <= '0;
                state        <= S_CLEAR;
              end
              gmg_pkg::OP_STEP: begin
                if (count == '0) begin
                  done   <= 1'b1;
                  result <= '{status: gmg_pkg::ST_EMPTY, out_x: 5'd0, out_y: 5'd0,
                              passage_dir: gmg_pkg::DIR_RIGHT, open_sides: 4'd0,
                              frontier_size: 11'd0};
                end else begin
                  state <= S_DIV1;
                end
              end
              gmg_pkg::OP_READ: begin
                state <= S_RDRQ;
              end
              default: begin
              end
            endcase
          end
        end
        S_SEED: begin
          if (step[2]) begin
            done         <= 1'b1;
            result       <= '{status: gmg_pkg::ST_START, out_x: 5'(seed_x), out_y: 5'(seed_y),
                              passage_dir: gmg_pkg::DIR_RIGHT, open_sides: 4'd0,
                              frontier_size: 11'(count)};
            seed_pending <= 1'b0;
            state        <= S_IDLE;
          end else begin
            if (nbr_ok) begin
              count <= count + PW'(1);
            end
            step <= step + 3'd1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            pick      <= div_rem;
            pick_wait <= 2'd0;
            state     <= S_PICK;
          end
        end
        S_PICK: begin
          pick_wait <= pick_wait + 2'd1;
          if (pick_wait == 2'd2) begin
            ent_x <= sel_entry[CW-1:0];
            ent_y <= sel_entry[EW-1:CW];
            count <= count - PW'(1);
            state <= S_OWNRQ;
          end
        end
        S_OWNRQ: begin
          state <= S_OWNWT;
        end
        S_OWNWT: begin
          own_word <= fresh_word;
          step     <= '0;
          nc       <= '0;
          state    <= S_NBRRQ;
        end
        S_NBRRQ: begin
          if (nbr_ok) begin
            nq_x   <= nbr_x;
            nq_y   <= nbr_y;
            nq_dir <= scan_dir;
            state  <= S_NBRWT;
          end else begin
            step <= step + 3'd1;
            if (step[1:0] == 2'd3) begin
              state <= S_AFTER;
            end
          end
        end
        S_NBRWT: begin
          if (mem_rd.visited) begin
            cand_dir[nc[1:0]] <= nq_dir;
            cand_x[nc[1:0]]   <= nq_x;
            cand_y[nc[1:0]]   <= nq_y;
            nc                <= nc + 3'd1;
          end else if (!mem_rd.queued) begin
            count <= count + PW'(1);
          end
          step  <= step + 3'd1;
          state <= (step[1:0] == 2'd3) ? S_AFTER : S_NBRRQ;
        end
        S_AFTER: begin
          if (nc == 3'd0) begin
            // Orphan cell: no passage opened
            done   <= 1'b1;
            result <= '{status: gmg_pkg::ST_ADDED, out_x: 5'(ent_x), out_y: 5'(ent_y),
                        passage_dir: gmg_pkg::DIR_RIGHT, open_sides: own_word.walls,
                        frontier_size: 11'(count)};
            state  <= S_IDLE;
          end else begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            pdir  <= cand_dir[div_rem[1:0]];
            tgt_x <= cand_x[div_rem[1:0]];
            tgt_y <= cand_y[div_rem[1:0]];
            state <= S_OPRQ;
          end
        end
        S_OPRQ: begin
          state <= S_OPWT;
        end
        S_OPWT: begin
          state <= S_OPOWN;
        end
        S_OPOWN: begin
          done   <= 1'b1;
          result <= '{status: gmg_pkg::ST_ADDED, out_x: 5'(ent_x), out_y: 5'(ent_y),
                      passage_dir: pdir,
                      open_sides: own_word.walls | gmg_pkg::dir_bit(pdir),
                      frontier_size: 11'(count)};
          state  <= S_IDLE;
        end
        S_RDRQ: begin
          state <= S_RDWT;
        end
        S_RDWT: begin
          done   <= 1'b1;
          result <= '{status: gmg_pkg::ST_READ, out_x: cmd_q.cell_x, out_y: cmd_q.cell_y,
                      passage_dir: gmg_pkg::DIR_RIGHT,
                      open_sides: rd_ok ? mem_rd.walls : 4'd0,
                      frontier_size: 11'(count)};
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The frontier never outgrows the grid
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PW'(CELL_COUNT))
    else $error("frontier count beyond cell count");

  // An unused opcode yields no result word
  a_none_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.opcode == gmg_pkg::OP_NONE)) |=> !done)
    else $error("result word after unused opcode");

  // A maze-complete word reports an empty frontier
  a_empty_size: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == gmg_pkg::ST_EMPTY)) |-> (result.frontier_size == 11'd0))
    else $error("complete status with frontier left");

  // A result word only follows a state that produces one
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_IDLE || $past(state) == S_SEED || $past(state) == S_AFTER ||
              $past(state) == S_OPOWN || $past(state) == S_RDWT))
    else $error("result word from a working state");

endmodule

FILE: verif/grid_maze_generator_tb.sv
// Self-checking testbench of the grid maze generator: directed table, then random builds.
`timescale 1ns / 100ps

module grid_maze_generator_tb;

  localparam int COLS     = 32;
  localparam int ROWS     = 32;
  localparam int CELLS    = COLS * ROWS;
  localparam int SETTLE   = 100;
  localparam int STALL_MAX = 4000;

  localparam logic [5:0] SIZES_W [12] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd4, 6'd2, 6'd8, 6'd3,
                                          6'd32, 6'd5, 6'd6, 6'd7};
  localparam logic [5:0] SIZES_H [12] = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd4, 6'd7, 6'd2, 6'd5,
                                          6'd2, 6'd6, 6'd3, 6'd8};

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  gmg_pkg::in_word_t   cmd;
  logic                done;
  gmg_pkg::out_word_t  result;
  logic                wr_en;
  logic                wr_index;
  logic [5:0]          wr_data;

  grid_maze_generator #(.MAX_COLUMNS(COLS), .MAX_ROWS(ROWS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // Maze model state
  bit        cell_seen [CELLS];
  bit        cell_queued [CELLS];
  bit [3:0]  cell_walls [CELLS];
  int        frontier [$];
  int        cols_used;
  int        rows_used;

  gmg_pkg::out_word_t maze_words [$];
  int        errors;
  int        stall_cycles;
  int        idle_pct;

  typedef struct {
    gmg_pkg::in_word_t  w;
    bit                 typed;
    gmg_pkg::out_word_t e;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_size(input logic [5:0] v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  // Neighbor of (x,y) toward d inside the grid in use
  function automatic bit next_cell(input int x, input int y, input logic [1:0] d,
                                   output int idx);
    int nx;
    int ny;
    nx = x;
    ny = y;
    idx = 0;
    case (d)
      gmg_pkg::DIR_RIGHT: begin
        if (x + 1 >= cols_used) return 0;
        nx = x + 1;
      end
      gmg_pkg::DIR_UP: begin
        if (y == 0) return 0;
        ny = y - 1;
      end
      gmg_pkg::DIR_LEFT: begin
        if (x == 0) return 0;
        nx = x - 1;
      end
      default: begin
        if (y + 1 >= rows_used) return 0;
        ny = y + 1;
      end
    endcase
    if (nx >= COLS || ny >= ROWS) return 0;
    idx = ny * COLS + nx;
    return 1;
  endfunction

  function automatic void add_frontier(input int idx);
    if (frontier.size() < CELLS) begin
      frontier.insert(frontier.size(), idx);
      cell_queued[idx] = 1'b1;
    end
  endfunction

  // Advance the maze model by one command word; returns 0 when no result
  function automatic bit grow_maze(input gmg_pkg::in_word_t w, output gmg_pkg::out_word_t r);
    int x;
    int y;
    int idx;
    int nidx;
    int pick;
    int nc;
    logic [1:0] cand_dir [4];
    int cand_idx [4];
    r = '0;
    case (w.opcode)
      gmg_pkg::OP_START: begin
        foreach (cell_seen[i]) begin
          cell_seen[i] = 1'b0;
          cell_queued[i] = 1'b0;
          cell_walls[i] = '0;
        end
        frontier = {};
        x = (w.cell_x >= cols_used) ? cols_used - 1 : int'(w.cell_x);
        y = (w.cell_y >= rows_used) ? rows_used - 1 : int'(w.cell_y);
        for (int i = 0; i < 4; i++)
          if (next_cell(x, y, gmg_pkg::SCAN_ORDER[i], nidx)) add_frontier(nidx);
        cell_seen[y * COLS + x] = 1'b1;
        r.status = gmg_pkg::ST_START;
        r.out_x = 5'(x);
        r.out_y = 5'(y);
      end
      gmg_pkg::OP_STEP: begin
        if (frontier.size() == 0) begin
          r.status = gmg_pkg::ST_EMPTY;
        end else begin
          pick = int'(w.pick_random % frontier.size());
          idx = frontier[pick];
          frontier.delete(pick);
          cell_queued[idx] = 1'b0;
          x = idx % COLS;
          y = idx / COLS;
          cell_seen[idx] = 1'b1;
          nc = 0;
          for (int i = 0; i < 4; i++) begin
            if (!next_cell(x, y, gmg_pkg::SCAN_ORDER[i], nidx)) continue;
            if (cell_seen[nidx]) begin
              cand_dir[nc] = gmg_pkg::SCAN_ORDER[i];
              cand_idx[nc] = nidx;
              nc++;
            end else if (!cell_queued[nidx]) begin
              add_frontier(nidx);
            end
          end
          // Open the wall on both sides toward the chosen visited neighbor
          if (nc != 0) begin
            pick = int'(w.passage_random % nc);
            r.passage_dir = cand_dir[pick];
            cell_walls[cand_idx[pick]] |= 4'b0001 << (cand_dir[pick] + 2'd2);
            cell_walls[idx] |= 4'b0001 << cand_dir[pick];
          end
          r.status = gmg_pkg::ST_ADDED;
          r.out_x = 5'(x);
          r.out_y = 5'(y);
          r.open_sides = cell_walls[idx];
        end
      end
      gmg_pkg::OP_READ: begin
        r.status = gmg_pkg::ST_READ;
        r.out_x = w.cell_x;
        r.out_y = w.cell_y;
        if (w.cell_x < cols_used && w.cell_y < rows_used)
          r.open_sides = cell_walls[w.cell_y * COLS + w.cell_x];
      end
      default: return 0;
    endcase
    r.frontier_size = 11'(frontier.size());
    return 1;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    gmg_pkg::out_word_t e;
    if (!rst && done) begin
      if (maze_words.size() == 0) begin
        report_mismatch("unexpected word", result.status, 0);
      end else begin
        e = maze_words.pop_front();
        if (result.status !== e.status) report_mismatch("status", result.status, e.status);
        if (result.out_x !== e.out_x) report_mismatch("out_x", result.out_x, e.out_x);
        if (result.out_y !== e.out_y) report_mismatch("out_y", result.out_y, e.out_y);
        if (result.passage_dir !== e.passage_dir)
          report_mismatch("passage_dir", result.passage_dir, e.passage_dir);
        if (result.open_sides !== e.open_sides)
          report_mismatch("open_sides", result.open_sides, e.open_sides);
        if (result.frontier_size !== e.frontier_size)
          report_mismatch("frontier_size", result.frontier_size, e.frontier_size);
      end
    end
  end

  // Watchdog on cycles with no accepted word either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one command word, hold until taken, then predict its result
  task automatic send_word(input gmg_pkg::in_word_t w);
    gmg_pkg::out_word_t r;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (busy);
    if (grow_maze(w, r)) maze_words.insert(maze_words.size(), r);
  endtask

  // Drain expectations, then let a trailing no-result word finish
  task automatic settle();
    start <= 1'b0;
    while (maze_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register; drop the enable for a cycle before the next write
  task automatic write_reg(input logic idx, input logic [5:0] v);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    if (idx == gmg_pkg::REG_GRID_WIDTH) cols_used = clamp_size(v, COLS);
    else rows_used = clamp_size(v, ROWS);
  endtask

  function automatic gmg_pkg::in_word_t make_word(input logic [1:0] op, input int x,
                                                  input int y, input logic [30:0] pr,
                                                  input logic [30:0] qr);
    gmg_pkg::in_word_t w;
    w.opcode = op;
    w.cell_x = 5'(x);
    w.cell_y = 5'(y);
    w.pick_random = pr;
    w.passage_random = qr;
    return w;
  endfunction

  function automatic gmg_pkg::out_word_t make_result(input logic [1:0] st, input int x,
                                                     input int y, input int fsize);
    gmg_pkg::out_word_t r;
    r = '0;
    r.status = st;
    r.out_x = 5'(x);
    r.out_y = 5'(y);
    r.frontier_size = 11'(fsize);
    return r;
  endfunction

  initial begin
    dir_row_t           table_rows [$];
    dir_row_t           row;
    gmg_pkg::in_word_t  w;
    int r;

    errors = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    wr_en = 1'b0;
    wr_index = gmg_pkg::REG_GRID_WIDTH;
    wr_data = '0;
    cols_used = 32;
    rows_used = 32;
    foreach (cell_seen[i]) begin
      cell_seen[i] = 1'b0;
      cell_queued[i] = 1'b0;
      cell_walls[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reads after reset, an empty step, an unused opcode, corner and middle seeds, extreme randoms
    table_rows = '{
      '{make_word(gmg_pkg::OP_READ, 0, 0, 0, 0), 1,
        make_result(gmg_pkg::ST_READ, 0, 0, 0)},
      '{make_word(gmg_pkg::OP_READ, 31, 31, '1, '1), 1,
        make_result(gmg_pkg::ST_READ, 31, 31, 0)},
      '{make_word(gmg_pkg::OP_STEP, 0, 0, '1, '1), 1,
        make_result(gmg_pkg::ST_EMPTY, 0, 0, 0)},
      '{make_word(gmg_pkg::OP_NONE, 31, 31, '1, '1), 0, '0},
      '{make_word(gmg_pkg::OP_START, 31, 31, 0, 0), 1,
        make_result(gmg_pkg::ST_START, 31, 31, 2)},
      '{make_word(gmg_pkg::OP_STEP, 0, 0, '1, '1), 0, '0},
      '{make_word(gmg_pkg::OP_STEP, 0, 0, 0, 0), 0, '0},
      '{make_word(gmg_pkg::OP_STEP, 0, 0, 31'h5555_5555, 31'h2AAA_AAAA), 0, '0},
      '{make_word(gmg_pkg::OP_READ, 31, 31, 0, 0), 0, '0},
      '{make_word(gmg_pkg::OP_START, 0, 0, '1, '1), 1,
        make_result(gmg_pkg::ST_START, 0, 0, 2)},
      '{make_word(gmg_pkg::OP_STEP, 0, 0, 1, 1), 0, '0},
      '{make_word(gmg_pkg::OP_STEP, 0, 0, 2, 3), 0, '0},
      '{make_word(gmg_pkg::OP_READ, 0, 0, 0, 0), 0, '0},
      '{make_word(gmg_pkg::OP_START, 10, 20, 0, 0), 1,
        make_result(gmg_pkg::ST_START, 10, 20, 4)},
      '{make_word(gmg_pkg::OP_STEP, 0, 0, 3, 0), 0, '0},
      '{make_word(gmg_pkg::OP_STEP, 0, 0, '1, 0), 0, '0},
      '{make_word(gmg_pkg::OP_STEP, 0, 0, 0, '1), 0, '0},
      '{make_word(gmg_pkg::OP_READ, 10, 20, 0, 0), 0, '0},
      '{make_word(gmg_pkg::OP_READ, 21, 10, 0, 0), 0, '0}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_word(row.w);
      if (row.typed) maze_words[$] = row.e;
    end
    settle();

    // Random builds over twelve grid settings; sender idling 8%, then 70%, then none
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 8 : (ph < 8) ? 70 : 0;
      write_reg(gmg_pkg::REG_GRID_WIDTH, SIZES_W[ph]);
      write_reg(gmg_pkg::REG_GRID_HEIGHT, SIZES_H[ph]);
      for (int n = 0; n < 80; n++) begin
        r = $urandom_range(0, 99);
        w.opcode = (r < 8) ? gmg_pkg::OP_START : (r < 80) ? gmg_pkg::OP_STEP :
                   (r < 95) ? gmg_pkg::OP_READ : gmg_pkg::OP_NONE;
        w.cell_x = 5'($urandom_range(0, 31));
        w.cell_y = 5'($urandom_range(0, 31));
        w.pick_random = 31'($urandom);
        w.passage_random = 31'($urandom);
        send_word(w);
      end
      settle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
